// ----- rtl/fstr_pkg.sv -----
// Shared types, codes and constants of the fan speed tach regulator.
// Used by every module of the block except the checker; depends on nothing.

package fstr_pkg;

	localparam int DUTY_W  = 10;
	localparam int COUNT_W = 16;
	localparam int DUST_W  = 3;
	localparam int MODE_W  = 2;
	localparam int VOTE_W  = 8;
	localparam int LEVEL_W = 2;
	localparam int LEVELS  = 3;
	// signed width for the deadband compares: count plus the widest band fits
	localparam int CMP_W   = 20;

	typedef enum logic [2:0] {
		KIND_TICK = 3'd0,
		KIND_TACH = 3'd1,
		KIND_STEP = 3'd2,
		KIND_ON   = 3'd3,
		KIND_OFF  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_INITIAL_MODE = 3'd0,
		REG_TARGET1      = 3'd1,
		REG_TARGET2      = 3'd2,
		REG_TARGET3      = 3'd3,
		REG_PRESET1      = 3'd4,
		REG_PRESET2      = 3'd5,
		REG_PRESET3      = 3'd6
	} reg_idx_t;

	localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;

	localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_1    = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_2    = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_3    = 2'd3;

	localparam logic [DUST_W-1:0] DUST_GOOD     = 3'd0;
	localparam logic [DUST_W-1:0] DUST_MEDIUM   = 3'd1;
	localparam logic [DUST_W-1:0] DUST_BAD      = 3'd2;
	localparam logic [DUST_W-1:0] DUST_GOOD_MED = 3'd3;
	localparam logic [DUST_W-1:0] DUST_MED_BAD  = 3'd4;

	localparam int NEAR_BAND    = 10;  // goal-to-preset window for single votes
	localparam int SNAP_EXTRA   = 100; // added to the biggest band on the high side
	localparam int LEVEL1_EXTRA = 3;   // low side band widening at level one
	localparam int VOTE_HIGH    = 22;
	localparam int VOTE_LOW     = 18;

	typedef struct packed {
		logic [MODE_W-1:0]                initial_mode;
		logic [LEVELS-1:0][COUNT_W-1:0]   target;
		logic [LEVELS-1:0][DUTY_W-1:0]    preset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		initial_mode: 2'd0,
		target:       {16'd700, 16'd500, 16'd300},
		preset:       {10'd600, 10'd400, 10'd200}
	};

	typedef struct packed {
		kind_t               kind;
		logic [COUNT_W-1:0]  tach_count;
		logic [DUST_W-1:0]   dust_level;
	} item_t;

	// packed so that pwm_duty lands in the lowest bits, as on the output word
	typedef struct packed {
		logic [DUTY_W-1:0] target_duty;
		logic [MODE_W-1:0] speed_mode;
		logic              drive_on;
		logic              pwm_enable;
		logic [DUTY_W-1:0] pwm_duty;
	} result_t;

	// level selected by the mode, or by the dust level in auto mode
	function automatic logic [LEVEL_W-1:0] pick_level(
		input logic [MODE_W-1:0] mode,
		input logic [DUST_W-1:0] dust
	);
		logic [LEVEL_W-1:0] lvl;
		if (mode != MODE_AUTO) begin
			lvl = mode;
		end else begin
			case (dust)
				DUST_GOOD:                               lvl = LEVEL_1;
				DUST_BAD:                                lvl = LEVEL_3;
				DUST_MEDIUM, DUST_GOOD_MED, DUST_MED_BAD: lvl = LEVEL_2;
				default:                                 lvl = LEVEL_NONE;
			endcase
		end
		return lvl;
	endfunction

	function automatic logic [DUTY_W-1:0] sel_preset(
		input cfg_t               cfg,
		input logic [LEVEL_W-1:0] lvl
	);
		logic [DUTY_W-1:0] p;
		case (lvl)
			LEVEL_1: p = cfg.preset[0];
			LEVEL_2: p = cfg.preset[1];
			LEVEL_3: p = cfg.preset[2];
			default: p = '0;
		endcase
		return p;
	endfunction

	function automatic logic [COUNT_W-1:0] sel_target(
		input cfg_t               cfg,
		input logic [LEVEL_W-1:0] lvl
	);
		logic [COUNT_W-1:0] t;
		case (lvl)
			LEVEL_1: t = cfg.target[0];
			LEVEL_2: t = cfg.target[1];
			LEVEL_3: t = cfg.target[2];
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/fstr_judge.sv -----
// Tach sample judge: deadband compare, vote update and goal step/snap.
// Pure combinational; depends on fstr_pkg.

module fstr_judge #(
	parameter int CORR_SMALL   = 10,
	parameter int CORR_BIG     = 30,
	parameter int CORR_BIGGEST = 100,
	parameter int JUDGE_STEP   = 3,
	parameter int JUDGE_CENTER = 20,
	parameter int DUTY_MAX     = 800
) (
	input  logic [fstr_pkg::MODE_W-1:0]  mode,
	input  logic [fstr_pkg::DUST_W-1:0]  dust_level,
	input  logic [fstr_pkg::COUNT_W-1:0] tach_count,
	input  logic [fstr_pkg::DUTY_W-1:0]  goal,
	input  logic [fstr_pkg::VOTE_W-1:0]  vote,
	input  fstr_pkg::cfg_t               cfg,
	output logic [fstr_pkg::DUTY_W-1:0]  goal_next,
	output logic [fstr_pkg::VOTE_W-1:0]  vote_next
);

	localparam int CW = fstr_pkg::CMP_W;
	localparam int VW = fstr_pkg::VOTE_W;
	localparam int DW = fstr_pkg::DUTY_W;

	localparam logic signed [CW-1:0] SMALL_S   = CW'(CORR_SMALL);
	localparam logic signed [CW-1:0] BIG_S     = CW'(CORR_BIG);
	localparam logic signed [CW-1:0] BIGGEST_S = CW'(CORR_BIGGEST);
	localparam logic signed [CW-1:0] SNAP_HI_S = CW'(CORR_BIGGEST + fstr_pkg::SNAP_EXTRA);
	localparam logic signed [CW-1:0] NEAR_S    = CW'(fstr_pkg::NEAR_BAND);
	localparam logic signed [CW-1:0] L1_S      = CW'(fstr_pkg::LEVEL1_EXTRA);

	localparam logic [VW-1:0] STEP_V   = VW'(JUDGE_STEP);
	localparam logic [VW-1:0] CENTER_V = VW'(JUDGE_CENTER);
	localparam logic [VW-1:0] HIGH_V   = VW'(fstr_pkg::VOTE_HIGH);
	localparam logic [VW-1:0] LOW_V    = VW'(fstr_pkg::VOTE_LOW);
	localparam logic [VW-1:0] ONE_V    = VW'(1);
	localparam logic [DW-1:0] DMAX     = DW'(DUTY_MAX);

	logic [fstr_pkg::LEVEL_W-1:0] lvl;
	logic [DW-1:0]                preset_sel;
	logic [DW-1:0]                preset_sat;
	logic signed [CW-1:0]         c_s, t_s, p_s, g_s, low_band;
	logic                         snap;
	logic [VW-1:0]                vote_j;
	logic [DW:0]                  goal_w;

	always_comb begin
		lvl        = fstr_pkg::pick_level(mode, dust_level);
		preset_sel = fstr_pkg::sel_preset(cfg, lvl);
		preset_sat = (preset_sel > DMAX) ? DMAX : preset_sel;
		c_s        = CW'(tach_count);
		t_s        = CW'(fstr_pkg::sel_target(cfg, lvl));
		p_s        = CW'(preset_sel);
		g_s        = CW'(goal);
		low_band   = (lvl == fstr_pkg::LEVEL_1) ? SMALL_S + L1_S : SMALL_S;
		snap       = 1'b0;
		vote_j     = vote;

		if (lvl != fstr_pkg::LEVEL_NONE) begin
			if (c_s < t_s - low_band) begin
				// running slow
				if (c_s < t_s - BIGGEST_S) begin
					snap = 1'b1;
				end else if (c_s < t_s - BIG_S) begin
					vote_j = vote + STEP_V;
				end else if (g_s < p_s + NEAR_S) begin
					vote_j = vote + ONE_V;
				end
			end else begin
				// running fast or inside the band
				if (c_s > t_s + SNAP_HI_S) begin
					snap = 1'b1;
				end else if (c_s > t_s + SMALL_S) begin
					if (c_s > t_s + BIG_S) begin
						vote_j = vote - STEP_V;
					end else if (g_s > p_s - NEAR_S) begin
						vote_j = vote - ONE_V;
					end
				end else begin
					vote_j = CENTER_V;
				end
			end
		end

		// vote threshold: step the goal by one and recenter
		goal_w    = {1'b0, snap ? preset_sat : goal};
		vote_next = vote_j;
		if (vote_j > HIGH_V) begin
			vote_next = CENTER_V;
			goal_w    = goal_w + (DW+1)'(1);
		end
		if (vote_next < LOW_V) begin
			vote_next = CENTER_V;
			if (goal_w != '0) begin
				goal_w = goal_w - (DW+1)'(1);
			end
		end
		goal_next = (goal_w > {1'b0, DMAX}) ? DMAX : goal_w[DW-1:0];
	end

endmodule

// ----- rtl/fstr_ctrl.sv -----
// Regulator state registers and the per-word next-state logic.
// Depends on fstr_pkg and fstr_judge.

module fstr_ctrl #(
	parameter int CORR_SMALL   = 10,
	parameter int CORR_BIG     = 30,
	parameter int CORR_BIGGEST = 100,
	parameter int JUDGE_STEP   = 3,
	parameter int JUDGE_CENTER = 20,
	parameter int DUTY_MAX     = 800
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  fstr_pkg::item_t   item,
	input  fstr_pkg::cfg_t    cfg,
	output fstr_pkg::result_t result_next
);

	localparam int DW = fstr_pkg::DUTY_W;
	localparam int VW = fstr_pkg::VOTE_W;
	localparam int MW = fstr_pkg::MODE_W;
	localparam logic [DW-1:0] DMAX     = DW'(DUTY_MAX);
	localparam logic [VW-1:0] CENTER_V = VW'(JUDGE_CENTER);

	logic          powered_q, enable_q, drive_q;
	logic [MW-1:0] mode_q;
	logic [DW-1:0] goal_q, ramp_q, duty_q;
	logic [VW-1:0] vote_q;

	logic          powered_n, enable_n, drive_n;
	logic [MW-1:0] mode_n;
	logic [DW-1:0] goal_n, ramp_n, duty_n;
	logic [VW-1:0] vote_n;

	logic [DW-1:0]                goal_tach;
	logic [VW-1:0]                vote_tach;
	logic [fstr_pkg::LEVEL_W-1:0] step_lvl;
	logic [DW-1:0]                step_preset;

	fstr_judge #(
		.CORR_SMALL  (CORR_SMALL),
		.CORR_BIG    (CORR_BIG),
		.CORR_BIGGEST(CORR_BIGGEST),
		.JUDGE_STEP  (JUDGE_STEP),
		.JUDGE_CENTER(JUDGE_CENTER),
		.DUTY_MAX    (DUTY_MAX)
	) u_judge (
		.mode      (mode_q),
		.dust_level(item.dust_level),
		.tach_count(item.tach_count),
		.goal      (goal_q),
		.vote      (vote_q),
		.cfg       (cfg),
		.goal_next (goal_tach),
		.vote_next (vote_tach)
	);

	always_comb begin
		powered_n   = powered_q;
		enable_n    = enable_q;
		drive_n     = drive_q;
		mode_n      = mode_q;
		goal_n      = goal_q;
		ramp_n      = ramp_q;
		duty_n      = duty_q;
		vote_n      = vote_q;
		step_lvl    = fstr_pkg::pick_level(mode_q + MW'(1), item.dust_level);
		step_preset = fstr_pkg::sel_preset(cfg, step_lvl);

		case (item.kind)
			fstr_pkg::KIND_TICK: begin
				if (powered_q) begin
					if (ramp_q != goal_q) begin
						ramp_n   = (ramp_q < goal_q) ? ramp_q + DW'(1) : ramp_q - DW'(1);
						duty_n   = ramp_n;
						enable_n = 1'b1;
					end
				end else if (goal_q != '0) begin
					// wind down: drive the goal itself as it falls
					goal_n   = goal_q - DW'(1);
					duty_n   = goal_n;
					enable_n = 1'b1;
				end else begin
					enable_n = 1'b0;
					drive_n  = 1'b0;
				end
			end
			fstr_pkg::KIND_TACH: begin
				if (powered_q) begin
					goal_n = goal_tach;
					vote_n = vote_tach;
				end
			end
			fstr_pkg::KIND_STEP: begin
				mode_n = mode_q + MW'(1);
				if (step_lvl != fstr_pkg::LEVEL_NONE) begin
					goal_n = (step_preset > DMAX) ? DMAX : step_preset;
				end
			end
			fstr_pkg::KIND_ON: begin
				powered_n = 1'b1;
				drive_n   = 1'b1;
				enable_n  = 1'b1;
				goal_n    = DW'(1);
				ramp_n    = '0;
				mode_n    = cfg.initial_mode;
			end
			fstr_pkg::KIND_OFF: begin
				powered_n = 1'b0;
			end
			default: begin
			end
		endcase

		result_next = '{
			target_duty: goal_n,
			speed_mode:  mode_n,
			drive_on:    drive_n,
			pwm_enable:  enable_n,
			pwm_duty:    duty_n
		};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			powered_q <= 1'b0;
			enable_q  <= 1'b0;
			drive_q   <= 1'b0;
			mode_q    <= fstr_pkg::MODE_AUTO;
			goal_q    <= '0;
			ramp_q    <= '0;
			duty_q    <= '0;
			vote_q    <= CENTER_V;
		end else if (step) begin
			powered_q <= powered_n;
			enable_q  <= enable_n;
			drive_q   <= drive_n;
			mode_q    <= mode_n;
			goal_q    <= goal_n;
			ramp_q    <= ramp_n;
			duty_q    <= duty_n;
			vote_q    <= vote_n;
		end
	end

endmodule

// ----- rtl/fan_speed_tach_regulator_unit.sv -----
// Top level of the fan speed tach regulator: stream ports, input and result
// registers, configuration registers. Depends on fstr_pkg and fstr_ctrl.
//
// Usage
//   Input stream (s_*): one word per event. s_tuser carries the event kind
//   (tick, tach sample, speed step, power on, power off); s_tdata carries
//   the tach count and the dust level. Every input word yields exactly one
//   output word on m_* with the driven PWM duty, PWM enable, fan drive,
//   speed mode and target duty as they stand after the event.
//   Configuration: cfg_we writes cfg_data into register cfg_index in the
//   same edge; write only while no word is in flight.
//   Path: an accepted word is held in the input register; its result is loaded
//   into the result register, which drives m_tdata, when the output is free.
//   Throughput: one word per cycle while the output is not stalled; the
//   next-state logic is combinational between the input and result registers.
//   Stall: a stalled result holds in the output register while one more
//   input word is taken into the input register; s_tready then drops until
//   the output drains.
//   Reset: arst_n clears both stages, the regulator state (off, auto mode,
//   duties 0, vote centered) and loads the default configuration.

module fan_speed_tach_regulator_unit #(
	parameter int CORR_SMALL   = 10,
	parameter int CORR_BIG     = 30,
	parameter int CORR_BIGGEST = 100,
	parameter int JUDGE_STEP   = 3,
	parameter int JUDGE_CENTER = 20,
	parameter int DUTY_MAX     = 800
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] tach_count, [18:16] dust_level, rest zero
	input  logic [2:0]  s_tuser,   // [2:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [9:0] pwm_duty, [10] pwm_enable, [11] drive_on,
	                               // [13:12] speed_mode, [23:14] target_duty
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CNT_W = fstr_pkg::COUNT_W;
	localparam int DST_W = fstr_pkg::DUST_W;

	fstr_pkg::cfg_t    cfg_q;
	fstr_pkg::item_t   item_s1;
	logic              valid_s1;
	fstr_pkg::result_t result_s2;
	fstr_pkg::result_t result_next;
	logic              valid_s2;
	logic              advance;

	// move the held word forward when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	// input register: payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind       <= fstr_pkg::kind_t'(s_tuser);
			item_s1.tach_count <= s_tdata[CNT_W-1:0];
			item_s1.dust_level <= s_tdata[CNT_W+DST_W-1:CNT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// result register: loads the state as it stands after the word
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	// configuration registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fstr_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (fstr_pkg::reg_idx_t'(cfg_index))
				fstr_pkg::REG_INITIAL_MODE: cfg_q.initial_mode <= cfg_data[fstr_pkg::MODE_W-1:0];
				fstr_pkg::REG_TARGET1:      cfg_q.target[0]    <= cfg_data[CNT_W-1:0];
				fstr_pkg::REG_TARGET2:      cfg_q.target[1]    <= cfg_data[CNT_W-1:0];
				fstr_pkg::REG_TARGET3:      cfg_q.target[2]    <= cfg_data[CNT_W-1:0];
				fstr_pkg::REG_PRESET1:      cfg_q.preset[0]    <= cfg_data[fstr_pkg::DUTY_W-1:0];
				fstr_pkg::REG_PRESET2:      cfg_q.preset[1]    <= cfg_data[fstr_pkg::DUTY_W-1:0];
				fstr_pkg::REG_PRESET3:      cfg_q.preset[2]    <= cfg_data[fstr_pkg::DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fstr_ctrl #(
		.CORR_SMALL  (CORR_SMALL),
		.CORR_BIG    (CORR_BIG),
		.CORR_BIGGEST(CORR_BIGGEST),
		.JUDGE_STEP  (JUDGE_STEP),
		.JUDGE_CENTER(JUDGE_CENTER),
		.DUTY_MAX    (DUTY_MAX)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.cfg        (cfg_q),
		.result_next(result_next)
	);

endmodule

// ----- rtl/fstr_checker.sv -----
// Port-level checks for the fan speed tach regulator, bound to the top level.
// Depends on fan_speed_tach_regulator_unit.

module fstr_checker #(
	parameter int DUTY_MAX = 800
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// input back-pressure only comes from a full, stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// target duty stays within the clamp
	a_goal_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:14] <= 10'(DUTY_MAX))
		else $error("target duty above maximum");

	// driven duty stays within the clamp
	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:0] <= 10'(DUTY_MAX))
		else $error("driven duty above maximum");

endmodule

bind fan_speed_tach_regulator_unit fstr_checker #(.DUTY_MAX(DUTY_MAX)) u_fstr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
